@@ sv/rbsi_pkg.sv @@
package rbsi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    // Magnitude of a scaled slab numerator and of its quotient
    localparam int MAG_BITS   = COORD_BITS + FRAC_BITS;
    // Signed slab distance, kept at full width
    localparam int DIST_BITS  = MAG_BITS + 1;
    // Divider: one operand stage, one stage per quotient bit, one sign stage
    localparam int DIV_LAT    = MAG_BITS + 2;
    localparam int MERGE_LAT  = 3;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIST_BITS-1:0]  dist_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_A_X = 3'd0,
        CFG_A_Y = 3'd1,
        CFG_A_Z = 3'd2,
        CFG_B_X = 3'd3,
        CFG_B_Y = 3'd4,
        CFG_B_Z = 3'd5
    } cfg_idx_t;

    // What one axis lane reports to the merge stage
    typedef struct packed {
        dist_t t_near;
        dist_t t_far;
        logic  par;
        logic  outside;
    } lane_res_t;

    // Ray data that rides alongside the lanes
    typedef struct packed {
        coord_t [NUM_AXES-1:0] origin;
        coord_t [NUM_AXES-1:0] dir;
        coord_t                wl;
        coord_t                wh;
    } side_t;

    typedef struct packed {
        logic                  hit;
        coord_t                distance;
        coord_t [NUM_AXES-1:0] point;
        axis_t                 normal_axis;
        logic                  normal_negative;
        logic                  front_face;
    } res_t;

endpackage

@@ sv/rbsi_ifs.sv @@
interface rbsi_ray_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   origin_x;
    logic signed [31:0]   origin_y;
    logic signed [31:0]   origin_z;
    logic signed [31:0]   dir_x;
    logic signed [31:0]   dir_y;
    logic signed [31:0]   dir_z;
    logic signed [31:0]   window_low;
    logic signed [31:0]   window_high;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                     window_low, window_high, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   window_low, window_high, output ready);
endinterface

interface rbsi_res_if;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [31:0]   distance;
    logic signed [31:0]   point_x;
    logic signed [31:0]   point_y;
    logic signed [31:0]   point_z;
    logic [1:0]           normal_axis;
    logic                 normal_negative;
    logic                 front_face;

    modport source (output valid, hit, distance, point_x, point_y, point_z, normal_axis,
                     normal_negative, front_face, input ready);
    modport sink (input valid, hit, distance, point_x, point_y, point_z, normal_axis,
                   normal_negative, front_face, output ready);
endinterface

interface rbsi_cfg_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           index;
    logic signed [31:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ray_box_slab_intersect.sv @@
// Path: an accepted ray beat writes the divider input register at the accept
// edge, then passes 49 further divider stages in each axis lane, 3 merge
// stages and 1 output register before it reaches its result beat.
// Throughput: one ray per cycle; the pipeline advances as a whole while the
// output skid register is empty.
// Reset: asynchronous, active low; clears all valids and sets the box to
// corner a = (0,0,0), corner b = (1.0,1.0,1.0).
module ray_box_slab_intersect (
    input  logic          clk,
    input  logic          rst_n,
    rbsi_ray_if.sink      ray,
    rbsi_res_if.source    res,
    rbsi_cfg_if.sink      cfg
);

    localparam int NA = rbsi_pkg::NUM_AXES;
    localparam int L  = rbsi_pkg::DIV_LAT;
    localparam rbsi_pkg::coord_t ONE = rbsi_pkg::coord_t'(1 << rbsi_pkg::FRAC_BITS);

    // Box registers
    rbsi_pkg::coord_t corner_a_reg [0:NA-1];
    rbsi_pkg::coord_t corner_b_reg [0:NA-1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NA; a++)
            begin
                corner_a_reg[a] <= '0;
                corner_b_reg[a] <= ONE;
            end
        end
        else if (cfg.valid)
        begin
            unique case (rbsi_pkg::cfg_idx_t'(cfg.index))
                rbsi_pkg::CFG_A_X: corner_a_reg[0] <= cfg.data;
                rbsi_pkg::CFG_A_Y: corner_a_reg[1] <= cfg.data;
                rbsi_pkg::CFG_A_Z: corner_a_reg[2] <= cfg.data;
                rbsi_pkg::CFG_B_X: corner_b_reg[0] <= cfg.data;
                rbsi_pkg::CFG_B_Y: corner_b_reg[1] <= cfg.data;
                rbsi_pkg::CFG_B_Z: corner_b_reg[2] <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline enable: hold while the skid register is occupied
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en        = !skid_valid_reg;
    assign ray.ready = en;

    rbsi_pkg::side_t side_in;
    assign side_in.origin = {ray.origin_z, ray.origin_y, ray.origin_x};
    assign side_in.dir    = {ray.dir_z, ray.dir_y, ray.dir_x};
    assign side_in.wl     = ray.window_low;
    assign side_in.wh     = ray.window_high;

    // Axis lanes
    rbsi_pkg::lane_res_t [NA-1:0] lanes;

    for (genvar a = 0; a < NA; a++)
    begin : g_lane
        rbsi_lane u_lane (
            .clk      (clk),
            .en       (en),
            .corner_a (corner_a_reg[a]),
            .corner_b (corner_b_reg[a]),
            .origin   (side_in.origin[a]),
            .dir      (side_in.dir[a]),
            .res      (lanes[a])
        );
    end

    // Carry the ray alongside the lanes
    rbsi_pkg::side_t side_reg [0:L-1];
    logic            side_valid_reg [0:L-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < L; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            side_valid_reg[0] <= ray.valid;
            for (int i = 1; i < L; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    // Merge stage
    logic           pipe_valid;
    rbsi_pkg::res_t pipe_res;

    rbsi_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (side_valid_reg[L-1]),
        .lanes     (lanes),
        .side      (side_reg[L-1]),
        .valid_out (pipe_valid),
        .res       (pipe_res)
    );

    // Output register and skid
    rbsi_pkg::res_t out_res_reg;
    rbsi_pkg::res_t skid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || res.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_valid;
            end
        end
        else if (en && pipe_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || res.ready)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : pipe_res;
        end
        else if (en)
        begin
            skid_res_reg <= pipe_res;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.hit             = out_res_reg.hit;
    assign res.distance        = out_res_reg.distance;
    assign res.point_x         = out_res_reg.point[0];
    assign res.point_y         = out_res_reg.point[1];
    assign res.point_z         = out_res_reg.point[2];
    assign res.normal_axis     = out_res_reg.normal_axis;
    assign res.normal_negative = out_res_reg.normal_negative;
    assign res.front_face      = out_res_reg.front_face;

endmodule

@@ sv/rbsi_div.sv @@
module rbsi_div (
    input  logic                   clk,
    input  logic                   en,
    input  rbsi_pkg::dist_t        num,
    input  rbsi_pkg::coord_t       den,
    output rbsi_pkg::dist_t        quo
);

    localparam int NB = rbsi_pkg::MAG_BITS;
    localparam int DB = rbsi_pkg::COORD_BITS;

    logic [NB-1:0] num_reg [0:NB];
    logic [DB-1:0] den_reg [0:NB];
    logic [DB-1:0] rem_reg [0:NB];
    logic          neg_reg [0:NB];
    rbsi_pkg::dist_t quo_reg;

    logic [DB:0]   num_abs_full;
    logic [rbsi_pkg::DIST_BITS-1:0] num_abs;

    // Take operand magnitudes; the quotient sign is the sign product
    assign num_abs = num[rbsi_pkg::DIST_BITS-1] ? -num : num;
    assign num_abs_full = den[DB-1] ? {1'b0, -den} : {1'b0, den};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= num_abs[NB-1:0];
            den_reg[0] <= num_abs_full[DB-1:0];
            rem_reg[0] <= '0;
            neg_reg[0] <= num[rbsi_pkg::DIST_BITS-1] ^ den[DB-1];
        end
    end

    // One quotient bit per stage, restoring
    for (genvar i = 0; i < NB; i++)
    begin : g_stage
        logic [DB:0] trial;
        logic        q_bit;
        logic [DB:0] diff;

        assign trial = {rem_reg[i], num_reg[i][NB-1]};
        assign diff  = trial - {1'b0, den_reg[i]};
        assign q_bit = (trial >= {1'b0, den_reg[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= q_bit ? diff[DB-1:0] : trial[DB-1:0];
                num_reg[i+1] <= {num_reg[i][NB-2:0], q_bit};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Apply the sign: truncation toward zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[NB] ? -rbsi_pkg::dist_t'({1'b0, num_reg[NB]})
                                   : rbsi_pkg::dist_t'({1'b0, num_reg[NB]});
        end
    end

    assign quo = quo_reg;

endmodule

@@ sv/rbsi_lane.sv @@
module rbsi_lane (
    input  logic                  clk,
    input  logic                  en,
    input  rbsi_pkg::coord_t      corner_a,
    input  rbsi_pkg::coord_t      corner_b,
    input  rbsi_pkg::coord_t      origin,
    input  rbsi_pkg::coord_t      dir,
    output rbsi_pkg::lane_res_t   res
);

    localparam int L = rbsi_pkg::DIV_LAT;
    localparam int CB = rbsi_pkg::COORD_BITS;

    rbsi_pkg::coord_t lo;
    rbsi_pkg::coord_t hi;
    logic signed [CB:0] diff_lo;
    logic signed [CB:0] diff_hi;
    rbsi_pkg::dist_t num_lo;
    rbsi_pkg::dist_t num_hi;
    rbsi_pkg::dist_t q_lo;
    rbsi_pkg::dist_t q_hi;

    logic par_reg     [0:L-1];
    logic outside_reg [0:L-1];
    logic dneg_reg    [0:L-1];

    // Order the corners and scale the plane offsets
    assign lo = (corner_a < corner_b) ? corner_a : corner_b;
    assign hi = (corner_a < corner_b) ? corner_b : corner_a;
    assign diff_lo = {lo[CB-1], lo} - {origin[CB-1], origin};
    assign diff_hi = {hi[CB-1], hi} - {origin[CB-1], origin};
    assign num_lo = {diff_lo, {rbsi_pkg::FRAC_BITS{1'b0}}};
    assign num_hi = {diff_hi, {rbsi_pkg::FRAC_BITS{1'b0}}};

    rbsi_div u_div_lo (.clk(clk), .en(en), .num(num_lo), .den(dir), .quo(q_lo));
    rbsi_div u_div_hi (.clk(clk), .en(en), .num(num_hi), .den(dir), .quo(q_hi));

    // Delay the slab flags to line up with the quotients
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg[0]     <= (dir == '0);
            outside_reg[0] <= (origin < lo) || (origin > hi);
            dneg_reg[0]    <= dir[CB-1];
            for (int i = 1; i < L; i++)
            begin
                par_reg[i]     <= par_reg[i-1];
                outside_reg[i] <= outside_reg[i-1];
                dneg_reg[i]    <= dneg_reg[i-1];
            end
        end
    end

    // Swap near and far for a negative direction
    always_comb
    begin
        res.t_near  = dneg_reg[L-1] ? q_hi : q_lo;
        res.t_far   = dneg_reg[L-1] ? q_lo : q_hi;
        res.par     = par_reg[L-1];
        res.outside = outside_reg[L-1];
    end

endmodule

@@ sv/rbsi_merge.sv @@
module rbsi_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  rbsi_pkg::lane_res_t [rbsi_pkg::NUM_AXES-1:0] lanes,
    input  rbsi_pkg::side_t                       side,
    output logic                                  valid_out,
    output rbsi_pkg::res_t                        res
);

    localparam int CB = rbsi_pkg::COORD_BITS;
    localparam int NA = rbsi_pkg::NUM_AXES;
    localparam int PB = 2 * CB;
    // Saturation bounds of a coordinate, held at product width
    localparam logic signed [PB-1:0] SAT_HI = {{(PB-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [PB-1:0] SAT_LO = {{(PB-CB+1){1'b1}}, {(CB-1){1'b0}}};

    // Stage A: combine the lanes
    rbsi_pkg::dist_t t_in;
    rbsi_pkg::dist_t t_out;
    rbsi_pkg::dist_t closest;
    logic            found_in;
    logic            found_far;
    logic            missed;
    rbsi_pkg::axis_t in_ax;
    rbsi_pkg::axis_t far_ax;
    rbsi_pkg::axis_t axis_a;
    rbsi_pkg::coord_t dir_sel;

    always_comb
    begin
        t_in      = rbsi_pkg::dist_t'(side.wl);
        t_out     = rbsi_pkg::dist_t'(side.wh);
        closest   = rbsi_pkg::dist_t'(side.wh);
        found_in  = 1'b0;
        found_far = 1'b0;
        missed    = 1'b0;
        in_ax     = rbsi_pkg::AXIS_X;
        far_ax    = rbsi_pkg::AXIS_X;
        for (int a = 0; a < NA; a++)
        begin
            if (lanes[a].par)
            begin
                missed = missed | lanes[a].outside;
            end
            else
            begin
                if (lanes[a].t_near > t_in)
                begin
                    t_in     = lanes[a].t_near;
                    found_in = 1'b1;
                    in_ax    = rbsi_pkg::axis_t'(2'(a));
                end
                if (lanes[a].t_far < t_out)
                begin
                    t_out = lanes[a].t_far;
                end
                if (lanes[a].t_far <= closest)
                begin
                    closest   = lanes[a].t_far;
                    found_far = 1'b1;
                    far_ax    = rbsi_pkg::axis_t'(2'(a));
                end
            end
        end
        axis_a = found_in ? in_ax : far_ax;
    end

    always_comb
    begin
        unique case (axis_a)
            rbsi_pkg::AXIS_X: dir_sel = side.dir[0];
            rbsi_pkg::AXIS_Y: dir_sel = side.dir[1];
            rbsi_pkg::AXIS_Z: dir_sel = side.dir[2];
            default:          dir_sel = side.dir[0];
        endcase
    end

    logic a_valid_reg;
    logic a_hit_reg;
    rbsi_pkg::coord_t a_thit_reg;
    rbsi_pkg::axis_t  a_axis_reg;
    logic a_neg_reg;
    logic a_front_reg;
    rbsi_pkg::coord_t [NA-1:0] a_origin_reg;
    rbsi_pkg::coord_t [NA-1:0] a_dir_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_hit_reg    <= !missed && (t_out > t_in) && (found_in || found_far);
            a_thit_reg   <= found_in ? t_in[CB-1:0] : t_out[CB-1:0];
            a_axis_reg   <= axis_a;
            a_neg_reg    <= (dir_sel > 0);
            a_front_reg  <= found_in;
            a_origin_reg <= side.origin;
            a_dir_reg    <= side.dir;
        end
    end

    // Stage B: distance times direction per axis
    logic b_valid_reg;
    logic b_hit_reg;
    rbsi_pkg::coord_t b_thit_reg;
    rbsi_pkg::axis_t  b_axis_reg;
    logic b_neg_reg;
    logic b_front_reg;
    rbsi_pkg::coord_t [NA-1:0] b_origin_reg;
    logic signed [PB-1:0] b_prod_reg [0:NA-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_hit_reg    <= a_hit_reg;
            b_thit_reg   <= a_thit_reg;
            b_axis_reg   <= a_axis_reg;
            b_neg_reg    <= a_neg_reg;
            b_front_reg  <= a_front_reg;
            b_origin_reg <= a_origin_reg;
            for (int a = 0; a < NA; a++)
            begin
                b_prod_reg[a] <= PB'(a_thit_reg * a_dir_reg[a]);
            end
        end
    end

    // Stage C: floor the product, add origin, saturate; clear on miss
    logic c_valid_reg;
    rbsi_pkg::res_t c_res_reg;
    logic signed [PB-1:0] sum [0:NA-1];
    rbsi_pkg::coord_t     pt  [0:NA-1];

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            sum[a] = PB'(b_origin_reg[a]) + (b_prod_reg[a] >>> rbsi_pkg::FRAC_BITS);
            if (sum[a] > SAT_HI)
            begin
                pt[a] = SAT_HI[CB-1:0];
            end
            else if (sum[a] < SAT_LO)
            begin
                pt[a] = SAT_LO[CB-1:0];
            end
            else
            begin
                pt[a] = sum[a][CB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_res_reg.hit             <= b_hit_reg;
            c_res_reg.distance        <= b_hit_reg ? b_thit_reg : '0;
            for (int a = 0; a < NA; a++)
            begin
                c_res_reg.point[a] <= b_hit_reg ? pt[a] : '0;
            end
            c_res_reg.normal_axis     <= b_hit_reg ? b_axis_reg : rbsi_pkg::AXIS_X;
            c_res_reg.normal_negative <= b_hit_reg & b_neg_reg;
            c_res_reg.front_face      <= b_hit_reg & b_front_reg;
        end
    end

    // Advance the stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign valid_out = c_valid_reg;
    assign res       = c_res_reg;

endmodule

@@ tb/ray_box_slab_intersect_test.sv @@
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic signed [31:0] wl;
        logic signed [31:0] wh;
    } ray_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] distance;
        logic signed [31:0] point [3];
        logic [1:0]         normal_axis;
        logic               normal_negative;
        logic               front_face;
    } hit_t;

    // Directed row: ray, whether the result is typed in, and that result
    typedef struct {
        ray_t r;
        bit   known;
        hit_t h;
    } row_t;

    localparam int LIMIT = 400000;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rbsi_ray_if ray_ch ();
    rbsi_res_if res_ch ();
    rbsi_cfg_if cfg_ch ();

    ray_box_slab_intersect dut (
        .clk   (clk),
        .rst_n (rst_n),
        .ray   (ray_ch.sink),
        .res   (res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    logic signed [31:0] box_lo_cfg [3];
    logic signed [31:0] box_hi_cfg [3];
    hit_t expected_hits [$];
    int   fails = 0;
    int   cycles = 0;
    bit   calm = 1'b0;
    int   hold_off = 0;
    row_t rows [$];

    // Floor of a product shifted down by the fraction bits
    function automatic logic signed [95:0] floor_q(input logic signed [95:0] p);
        return p >>> rbsi_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        if (v > 96'sh7fffffff)
            return MAXV;
        if (v < -96'sh80000000)
            return MINV;
        return v[31:0];
    endfunction

    // Slab test of one ray against the configured box
    function automatic hit_t slab_hit(input ray_t r);
        hit_t h;
        logic signed [95:0] lo, hi, o, d, t0, t1, tmp, t_in, t_out, t_hit, closest;
        logic signed [95:0] t_far [3];
        bit far_ok [3];
        int in_axis, ax;
        bit missed;
        h.hit = 0;
        h.distance = 0;
        h.normal_axis = 0;
        h.normal_negative = 0;
        h.front_face = 0;
        for (int a = 0; a < 3; a++)
            h.point[a] = 0;
        t_in = r.wl;
        t_out = r.wh;
        in_axis = -1;
        ax = -1;
        missed = 0;
        for (int a = 0; a < 3; a++)
        begin
            lo = (box_lo_cfg[a] < box_hi_cfg[a]) ? box_lo_cfg[a] : box_hi_cfg[a];
            hi = (box_lo_cfg[a] < box_hi_cfg[a]) ? box_hi_cfg[a] : box_lo_cfg[a];
            o = r.org[a];
            d = r.dir[a];
            far_ok[a] = 0;
            t_far[a] = 0;
            if (d == 0)
            begin
                if (o < lo || o > hi)
                    missed = 1;
                continue;
            end
            t0 = ((lo - o) * 96'sd65536) / d;
            t1 = ((hi - o) * 96'sd65536) / d;
            if (d < 0)
            begin
                tmp = t0;
                t0 = t1;
                t1 = tmp;
            end
            if (t0 > t_in)
            begin
                t_in = t0;
                in_axis = a;
            end
            if (t1 < t_out)
                t_out = t1;
            t_far[a] = t1;
            far_ok[a] = 1;
        end
        if (missed || t_out <= t_in)
            return h;
        if (in_axis >= 0)
        begin
            ax = in_axis;
            t_hit = t_in;
            h.front_face = 1;
        end
        else
        begin
            closest = r.wh;
            for (int a = 0; a < 3; a++)
                if (far_ok[a] && t_far[a] <= closest)
                begin
                    closest = t_far[a];
                    ax = a;
                end
            if (ax < 0)
                return h;
            t_hit = t_out;
        end
        h.hit = 1;
        h.distance = t_hit[31:0];
        for (int a = 0; a < 3; a++)
            h.point[a] = sat32(96'(r.org[a]) + floor_q(t_hit * 96'(r.dir[a])));
        h.normal_axis = ax[1:0];
        h.normal_negative = r.dir[ax] > 0;
        return h;
    endfunction

    function automatic ray_t mk_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz, wl, wh);
        ray_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        r.wl = wl;
        r.wh = wh;
        return r;
    endfunction

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? MAXV : MINV;
            default: return $signed($urandom_range(0, 6 * 65536)) - 3 * 65536;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_dir();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom;
            default: return $signed($urandom_range(1, 4 * 65536)) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    // Mostly rays aimed toward the box from nearby origins, some pure noise
    function automatic ray_t rnd_ray();
        ray_t r;
        logic signed [31:0] wl, wh;
        for (int a = 0; a < 3; a++)
        begin
            r.org[a] = rnd_coord();
            r.dir[a] = rnd_dir();
        end
        if ($urandom_range(0, 9) < 7)
        begin
            for (int a = 0; a < 3; a++)
            begin
                r.org[a] = $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
                r.dir[a] = (32'sd32768 - r.org[a]) + ($signed($urandom_range(0, 16384)) - 8192);
                if ($urandom_range(0, 9) == 0)
                    r.dir[a] = 0;
            end
        end
        case ($urandom_range(0, 5))
            0: begin wl = $urandom; wh = $urandom; end
            1: begin wl = MINV; wh = MAXV; end
            default: begin wl = $signed($urandom_range(0, 65536)) - 32768;
                           wh = $signed($urandom_range(0, 20 * 65536)); end
        endcase
        r.wl = wl;
        r.wh = wh;
        return r;
    endfunction

    function automatic hit_t miss_result();
        hit_t h;
        h.hit = 0; h.distance = 0; h.normal_axis = 0; h.normal_negative = 0;
        h.front_face = 0;
        for (int a = 0; a < 3; a++)
            h.point[a] = 0;
        return h;
    endfunction

    task automatic add_row(input ray_t r, input bit known, input hit_t h);
        row_t w;
        w.r = r;
        w.known = known;
        w.h = h;
        rows.push_back(w);
    endtask

    // Send one ray beat and queue its expected result; valid stays high
    // between back-to-back beats and drops only while idling
    task automatic send_ray(input ray_t r, input bit known, input hit_t h);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            ray_ch.valid <= 1'b0;
            @(negedge clk);
        end
        ray_ch.valid <= 1'b1;
        ray_ch.origin_x <= r.org[0];
        ray_ch.origin_y <= r.org[1];
        ray_ch.origin_z <= r.org[2];
        ray_ch.dir_x <= r.dir[0];
        ray_ch.dir_y <= r.dir[1];
        ray_ch.dir_z <= r.dir[2];
        ray_ch.window_low <= r.wl;
        ray_ch.window_high <= r.wh;
        do
            @(posedge clk);
        while (!ray_ch.ready);
        expected_hits.push_back(known ? h : slab_hit(r));
        @(negedge clk);
    endtask

    task automatic write_reg(input rbsi_pkg::cfg_idx_t idx, input logic signed [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx < rbsi_pkg::CFG_B_X)
            box_lo_cfg[idx] = v;
        else
            box_hi_cfg[idx - rbsi_pkg::CFG_B_X] = v;
        @(negedge clk);
    endtask

    task automatic drain();
        ray_ch.valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_box(input logic signed [31:0] ax, ay, az, bx, by, bz);
        write_reg(rbsi_pkg::CFG_A_X, ax);
        write_reg(rbsi_pkg::CFG_A_Y, ay);
        write_reg(rbsi_pkg::CFG_A_Z, az);
        write_reg(rbsi_pkg::CFG_B_X, bx);
        write_reg(rbsi_pkg::CFG_B_Y, by);
        write_reg(rbsi_pkg::CFG_B_Z, bz);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= calm || $urandom_range(0, 99) >= 15;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        hit_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("result beat with nothing expected");
                fails++;
            end
            else
            begin
                e = expected_hits.pop_front();
                if (res_ch.hit !== e.hit)
                begin
                    $error("hit exp %0d got %0d", e.hit, res_ch.hit); fails++;
                end
                if (res_ch.distance !== e.distance)
                begin
                    $error("distance exp %0d got %0d", e.distance, res_ch.distance); fails++;
                end
                if (res_ch.point_x !== e.point[0])
                begin
                    $error("point_x exp %0d got %0d", e.point[0], res_ch.point_x); fails++;
                end
                if (res_ch.point_y !== e.point[1])
                begin
                    $error("point_y exp %0d got %0d", e.point[1], res_ch.point_y); fails++;
                end
                if (res_ch.point_z !== e.point[2])
                begin
                    $error("point_z exp %0d got %0d", e.point[2], res_ch.point_z); fails++;
                end
                if (res_ch.normal_axis !== e.normal_axis)
                begin
                    $error("normal_axis exp %0d got %0d", e.normal_axis, res_ch.normal_axis);
                    fails++;
                end
                if (res_ch.normal_negative !== e.normal_negative)
                begin
                    $error("normal_negative exp %0d got %0d", e.normal_negative,
                           res_ch.normal_negative);
                    fails++;
                end
                if (res_ch.front_face !== e.front_face)
                begin
                    $error("front_face exp %0d got %0d", e.front_face, res_ch.front_face);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        hit_t h, mh;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = 0; ray_ch.origin_y = 0; ray_ch.origin_z = 0;
        ray_ch.dir_x = 0; ray_ch.dir_y = 0; ray_ch.dir_z = 0;
        ray_ch.window_low = 0; ray_ch.window_high = 0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = rbsi_pkg::CFG_A_X;
        cfg_ch.data = 0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo_cfg[a] = 0;
            box_hi_cfg[a] = ONE;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table against the reset box
        mh = miss_result();
        // Entry hit on the x face from the negative side
        h = mh;
        h.hit = 1; h.distance = ONE; h.point[0] = 0; h.point[1] = 32'sd32768;
        h.point[2] = 32'sd32768; h.normal_axis = rbsi_pkg::AXIS_X; h.normal_negative = 1;
        h.front_face = 1;
        add_row(mk_ray(-ONE, 32768, 32768, ONE, 0, 0, 0, 10 * ONE), 1, h);
        // Parallel slab with origin outside misses
        add_row(mk_ray(-ONE, 2 * ONE, 32768, ONE, 0, 0, 0, 10 * ONE), 1, mh);
        // Inverted and empty windows miss
        add_row(mk_ray(-ONE, 32768, 32768, ONE, 0, 0, 10 * ONE, 0), 1, mh);
        add_row(mk_ray(-ONE, 32768, 32768, ONE, 0, 0, ONE, ONE), 1, mh);
        // Origin inside: exit hit, back face
        add_row(mk_ray(32768, 32768, 32768, 0, ONE, 0, 0, 10 * ONE), 0, mh);
        // Window lying inside the box misses
        add_row(mk_ray(32768, 32768, 32768, 0, ONE, 0, 0, 100), 0, mh);
        // Negative directions, z face, ties
        add_row(mk_ray(32768, 32768, 3 * ONE, 0, 0, -ONE, 0, 10 * ONE), 0, mh);
        add_row(mk_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 10 * ONE), 0, mh);
        add_row(mk_ray(32768, 32768, 32768, ONE, ONE, ONE, MINV, MAXV), 0, mh);
        // Field extremes and saturation
        add_row(mk_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV), 0, mh);
        add_row(mk_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV), 0, mh);
        add_row(mk_ray(MINV, 32768, 32768, 1, 0, 0, 0, MAXV), 0, mh);
        add_row(mk_ray(0, 0, 0, -1, -1, -1, MINV, MAXV), 0, mh);
        add_row(mk_ray(-1, -1, -1, 0, 0, 0, MINV, MAXV), 1, mh);
        add_row(mk_ray(ONE, ONE, ONE, 0, 0, 0, MINV, MAXV), 0, mh);
        foreach (rows[i])
            send_ray(rows[i].r, rows[i].known, rows[i].h);
        drain();

        // Swapped corners and extreme boxes
        set_box(2 * ONE, ONE, 3 * ONE, -ONE, -2 * ONE, ONE);
        for (int i = 0; i < 60; i++)
            send_ray(rnd_ray(), 0, mh);
        drain();
        set_box(MINV, MINV, MINV, MAXV, MAXV, MAXV);
        for (int i = 0; i < 60; i++)
            send_ray(rnd_ray(), 0, mh);
        drain();
        set_box(MAXV, 0, MINV, MAXV, 0, MINV);
        for (int i = 0; i < 40; i++)
            send_ray(rnd_ray(), 0, mh);
        drain();

        // Back to a unit box; long stall on the result side with rays still offered
        set_box(0, 0, 0, ONE, ONE, ONE);
        hold_off = 150;
        for (int i = 0; i < 100; i++)
            send_ray(rnd_ray(), 0, mh);
        // Stretch with no idling at all
        calm = 1'b1;
        for (int i = 0; i < 80; i++)
            send_ray(rnd_ray(), 0, mh);
        calm = 1'b0;
        for (int i = 0; i < 60; i++)
            send_ray(rnd_ray(), 0, mh);
        drain();

        if (fails == 0 && expected_hits.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ ray_box_slab_intersect.f @@
sv/rbsi_pkg.sv
sv/rbsi_ifs.sv
sv/rbsi_div.sv
sv/rbsi_lane.sv
sv/rbsi_merge.sv
sv/ray_box_slab_intersect.sv
tb/ray_box_slab_intersect_test.sv
